// ===== rtl/ter_pkg.sv =====
// ----------------------------------------------------------------------------
// ter_pkg
// Shared widths, register indexes and the setup bundle of the triangle
// edge rasterizer.
// ----------------------------------------------------------------------------
package ter_pkg;

   localparam int COORD_BITS   = 12;
   localparam int DIFF_BITS    = COORD_BITS + 1;
   localparam int PROD_BITS    = 2 * DIFF_BITS;
   localparam int EDGE_BITS    = 2 * COORD_BITS + 3;
   localparam int ARGB_BITS    = 32;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int SETTLE_BITS  = 2;

   localparam logic [SETTLE_BITS-1:0] SETTLE_CYCLES = 2'd3;

   localparam logic [ARGB_BITS-1:0] ALPHA_MASK   = 32'hFF00_0000;
   localparam logic [ARGB_BITS-1:0] RGB_DIM_MASK = 32'h00FC_FCFC;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_VERTEX_A_X,
      CSR_VERTEX_A_Y,
      CSR_VERTEX_B_X,
      CSR_VERTEX_B_Y,
      CSR_VERTEX_C_X,
      CSR_VERTEX_C_Y,
      CSR_FILL_ARGB,
      CSR_DIM_ENABLE
   } ter_csr_type;

   typedef logic [EDGE_BITS-1:0] ter_edge_type;

   // Values derived from the configuration, handed to the scanner
   typedef struct packed {
      logic [COORD_BITS-1:0]  min_x;
      logic [COORD_BITS-1:0]  min_y;
      logic [COORD_BITS-1:0]  max_x;
      logic [COORD_BITS-1:0]  max_y;
      ter_edge_type [2:0]     step_x;
      ter_edge_type [2:0]     step_y;
      ter_edge_type [2:0]     corner;
      logic [ARGB_BITS-1:0]   argb;
      logic                   busy;
   } ter_setup_type;

endpackage

// ===== rtl/triangle_edge_rasterizer_core.sv =====
// ----------------------------------------------------------------------------
// triangle_edge_rasterizer_core
// Edge-function triangle rasterizer: one bounding box position per word.
// ----------------------------------------------------------------------------
// A result word is registered in the cycle after its request word is taken.
// Throughput: one word per cycle while the request side is not stalled, set by the edge update loop.
// After each register write the request side stalls while the bounding box,
// the edge products and the corner edge values are formed.
// Reset is synchronous, active high; it clears the configuration and scan
// state and also starts that same settle stall.
module triangle_edge_rasterizer_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_restart,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ter_pkg::COORD_BITS-1:0]    rsp_pixel_x,
   output logic [ter_pkg::COORD_BITS-1:0]    rsp_pixel_y,
   output logic                              rsp_inside_res,
   output logic [ter_pkg::ARGB_BITS-1:0]     rsp_pixel_argb,
   output logic                              rsp_last,
   input  logic                              csr_we,
   input  logic [ter_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [ter_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import ter_pkg::*;

   ter_setup_type setup;
   logic          take;

   // Stall while settling or while the result word is held
   assign req_stall = setup.busy || (rsp_valid && rsp_stall);
   assign take      = req_valid && !req_stall;

   ter_setup u_setup (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .setup     (setup)
   );

   ter_scan u_scan (
      .clock          (clock),
      .reset          (reset),
      .setup          (setup),
      .take           (take),
      .restart        (req_restart),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_inside_res (rsp_inside_res),
      .rsp_pixel_argb (rsp_pixel_argb),
      .rsp_last       (rsp_last)
   );

endmodule

// ===== rtl/ter_setup.sv =====
// ----------------------------------------------------------------------------
// ter_setup
// Configuration registers, bounding box, edge increments and the edge
// values at the box corner, formed over a short pipeline after each write.
// ----------------------------------------------------------------------------
module ter_setup (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [ter_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [ter_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   output ter_pkg::ter_setup_type            setup
);
   import ter_pkg::*;

   logic [COORD_BITS-1:0] vx_ff [3];
   logic [COORD_BITS-1:0] vy_ff [3];
   logic [ARGB_BITS-1:0]  fill_ff;
   logic                  dim_ff;

   logic [COORD_BITS-1:0] min_x_ff, min_y_ff, max_x_ff, max_y_ff;
   logic [COORD_BITS-1:0] min_x_in, min_y_in, max_x_in, max_y_in;

   logic signed [PROD_BITS-1:0] prod_a_ff [3];
   logic signed [PROD_BITS-1:0] prod_b_ff [3];
   logic signed [PROD_BITS-1:0] prod_a_in [3];
   logic signed [PROD_BITS-1:0] prod_b_in [3];
   ter_edge_type                corner_ff [3];
   ter_edge_type                corner_in [3];

   logic [SETTLE_BITS-1:0] settle_ff, settle_in;

   logic [COORD_BITS-1:0] px [3];
   logic [COORD_BITS-1:0] py [3];
   logic [COORD_BITS-1:0] qx [3];
   logic [COORD_BITS-1:0] qy [3];
   logic signed [DIFF_BITS-1:0] dx_min [3];
   logic signed [DIFF_BITS-1:0] dy_edge [3];
   logic signed [DIFF_BITS-1:0] dx_edge [3];
   logic signed [DIFF_BITS-1:0] dy_min [3];
   logic signed [DIFF_BITS-1:0] step_x_d [3];

   // Take register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            vx_ff[i] <= '0;
            vy_ff[i] <= '0;
         end
         fill_ff <= '0;
         dim_ff  <= 1'b0;
      end else if (csr_we) begin
         case (ter_csr_type'(csr_index))
            CSR_VERTEX_A_X: vx_ff[0] <= csr_wdata[COORD_BITS-1:0];
            CSR_VERTEX_A_Y: vy_ff[0] <= csr_wdata[COORD_BITS-1:0];
            CSR_VERTEX_B_X: vx_ff[1] <= csr_wdata[COORD_BITS-1:0];
            CSR_VERTEX_B_Y: vy_ff[1] <= csr_wdata[COORD_BITS-1:0];
            CSR_VERTEX_C_X: vx_ff[2] <= csr_wdata[COORD_BITS-1:0];
            CSR_VERTEX_C_Y: vy_ff[2] <= csr_wdata[COORD_BITS-1:0];
            CSR_FILL_ARGB:  fill_ff  <= csr_wdata[ARGB_BITS-1:0];
            CSR_DIM_ENABLE: dim_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Edge endpoints: a->b, b->c, c->a
   always_comb begin
      px[0] = vx_ff[0]; py[0] = vy_ff[0]; qx[0] = vx_ff[1]; qy[0] = vy_ff[1];
      px[1] = vx_ff[1]; py[1] = vy_ff[1]; qx[1] = vx_ff[2]; qy[1] = vy_ff[2];
      px[2] = vx_ff[2]; py[2] = vy_ff[2]; qx[2] = vx_ff[0]; qy[2] = vy_ff[0];
   end

   // Bounding box
   always_comb begin
      min_x_in = (vx_ff[0] < vx_ff[1]) ? vx_ff[0] : vx_ff[1];
      min_x_in = (min_x_in < vx_ff[2]) ? min_x_in : vx_ff[2];
      min_y_in = (vy_ff[0] < vy_ff[1]) ? vy_ff[0] : vy_ff[1];
      min_y_in = (min_y_in < vy_ff[2]) ? min_y_in : vy_ff[2];
      max_x_in = (vx_ff[0] > vx_ff[1]) ? vx_ff[0] : vx_ff[1];
      max_x_in = (max_x_in > vx_ff[2]) ? max_x_in : vx_ff[2];
      max_y_in = (vy_ff[0] > vy_ff[1]) ? vy_ff[0] : vy_ff[1];
      max_y_in = (max_y_in > vy_ff[2]) ? max_y_in : vy_ff[2];
   end

   // Differences, products and corner edge values
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         dx_min[k]   = $signed({1'b0, px[k]}) - $signed({1'b0, min_x_ff});
         dy_min[k]   = $signed({1'b0, py[k]}) - $signed({1'b0, min_y_ff});
         dy_edge[k]  = $signed({1'b0, qy[k]}) - $signed({1'b0, py[k]});
         dx_edge[k]  = $signed({1'b0, qx[k]}) - $signed({1'b0, px[k]});
         step_x_d[k] = $signed({1'b0, py[k]}) - $signed({1'b0, qy[k]});
         prod_a_in[k] = dx_min[k] * dy_edge[k];
         prod_b_in[k] = dx_edge[k] * dy_min[k];
         corner_in[k] = {{(EDGE_BITS-PROD_BITS){prod_a_ff[k][PROD_BITS-1]}}, prod_a_ff[k]}
                      - {{(EDGE_BITS-PROD_BITS){prod_b_ff[k][PROD_BITS-1]}}, prod_b_ff[k]};
      end
   end

   // Advance the derived pipeline every cycle
   always_ff @(posedge clock) begin
      min_x_ff <= min_x_in;
      min_y_ff <= min_y_in;
      max_x_ff <= max_x_in;
      max_y_ff <= max_y_in;
      for (int k = 0; k < 3; k++) begin
         prod_a_ff[k] <= prod_a_in[k];
         prod_b_ff[k] <= prod_b_in[k];
         corner_ff[k] <= corner_in[k];
      end
   end

   // Hold the scanner off until the pipeline has settled
   always_comb begin
      if (csr_we) begin
         settle_in = SETTLE_CYCLES;
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - 1'b1;
      end else begin
         settle_in = settle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= SETTLE_CYCLES;
      end else begin
         settle_ff <= settle_in;
      end
   end

   // Bundle the results
   always_comb begin
      setup.min_x = min_x_ff;
      setup.min_y = min_y_ff;
      setup.max_x = max_x_ff;
      setup.max_y = max_y_ff;
      for (int k = 0; k < 3; k++) begin
         setup.step_x[k] = {{(EDGE_BITS-DIFF_BITS){step_x_d[k][DIFF_BITS-1]}}, step_x_d[k]};
         setup.step_y[k] = {{(EDGE_BITS-DIFF_BITS){dx_edge[k][DIFF_BITS-1]}}, dx_edge[k]};
         setup.corner[k] = corner_ff[k];
      end
      setup.argb = dim_ff ? ((fill_ff & ALPHA_MASK) | ((fill_ff & RGB_DIM_MASK) >> 2))
                          : fill_ff;
      setup.busy = csr_we || (settle_ff != '0);
   end

endmodule

// ===== rtl/ter_scan.sv =====
// ----------------------------------------------------------------------------
// ter_scan
// Scan state over the bounding box with incremental edge values, inside
// test and the result word register.
// ----------------------------------------------------------------------------
module ter_scan (
   input  logic                           clock,
   input  logic                           reset,
   input  ter_pkg::ter_setup_type         setup,
   input  logic                           take,
   input  logic                           restart,
   input  logic                           rsp_stall,
   output logic                           rsp_valid,
   output logic [ter_pkg::COORD_BITS-1:0] rsp_pixel_x,
   output logic [ter_pkg::COORD_BITS-1:0] rsp_pixel_y,
   output logic                           rsp_inside_res,
   output logic [ter_pkg::ARGB_BITS-1:0]  rsp_pixel_argb,
   output logic                           rsp_last
);
   import ter_pkg::*;

   logic [COORD_BITS-1:0] x_ff, x_in, y_ff, y_in;
   ter_edge_type          now_ff [3];
   ter_edge_type          now_in [3];
   ter_edge_type          col_ff [3];
   ter_edge_type          col_in [3];
   logic                  active_ff, active_in;
   logic                  produce, is_last, nonneg, nonpos;

   logic                  valid_ff, valid_in;
   logic [COORD_BITS-1:0] px_ff, py_ff;
   logic                  inside_ff, last_ff;
   logic [ARGB_BITS-1:0]  argb_ff;

   // Step the scan position and edge values
   always_comb begin
      produce = take && (restart || active_ff);
      x_in = x_ff;
      y_in = y_ff;
      for (int k = 0; k < 3; k++) begin
         now_in[k] = now_ff[k];
         col_in[k] = col_ff[k];
      end
      if (restart) begin
         x_in = setup.min_x;
         y_in = setup.min_y;
         for (int k = 0; k < 3; k++) begin
            col_in[k] = setup.corner[k];
            now_in[k] = setup.corner[k];
         end
      end else if (y_ff < setup.max_y) begin
         y_in = y_ff + 1'b1;
         for (int k = 0; k < 3; k++) begin
            now_in[k] = now_ff[k] + setup.step_y[k];
         end
      end else begin
         y_in = setup.min_y;
         x_in = x_ff + 1'b1;
         for (int k = 0; k < 3; k++) begin
            col_in[k] = col_ff[k] + setup.step_x[k];
            now_in[k] = col_in[k];
         end
      end
      is_last = (x_in == setup.max_x) && (y_in == setup.max_y);
      active_in = produce ? !is_last : active_ff;
   end

   // Inside when no edge is negative, or no edge is positive
   always_comb begin
      nonneg = 1'b1;
      nonpos = 1'b1;
      for (int k = 0; k < 3; k++) begin
         if (now_in[k][EDGE_BITS-1]) begin
            nonneg = 1'b0;
         end else if (now_in[k] != '0) begin
            nonpos = 1'b0;
         end
      end
   end

   // Hold a word until the consumer takes it
   always_comb begin
      if (produce) begin
         valid_in = 1'b1;
      end else begin
         valid_in = valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff      <= '0;
         y_ff      <= '0;
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            now_ff[k] <= '0;
            col_ff[k] <= '0;
         end
      end else begin
         valid_ff  <= valid_in;
         active_ff <= active_in;
         if (produce) begin
            x_ff <= x_in;
            y_ff <= y_in;
            for (int k = 0; k < 3; k++) begin
               now_ff[k] <= now_in[k];
               col_ff[k] <= col_in[k];
            end
         end
      end
   end

   // Load the result word
   always_ff @(posedge clock) begin
      if (produce) begin
         px_ff     <= x_in;
         py_ff     <= y_in;
         inside_ff <= nonneg || nonpos;
         argb_ff   <= setup.argb;
         last_ff   <= is_last;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_pixel_x    = px_ff;
   assign rsp_pixel_y    = py_ff;
   assign rsp_inside_res = inside_ff;
   assign rsp_pixel_argb = argb_ff;
   assign rsp_last       = last_ff;

endmodule
